// ----- hw/rtl/ptmi_pkg.sv -----
// Shared types and constants for the page table map insert block.
// Used by ptmi_ctrl, ptmi_dp and page_table_map_insert; depends on nothing.
package ptmi_pkg;

   // Table pool geometry
   localparam int POOL_PAGES       = 64;
   localparam int ENTRIES_PER_PAGE = 512;
   localparam int IDX_W            = 9;
   localparam int PAGE_W           = $clog2(POOL_PAGES);
   localparam int STORE_DEPTH      = POOL_PAGES * ENTRIES_PER_PAGE;
   localparam int STORE_ADDR_W     = PAGE_W + IDX_W;
   localparam int NFP_W            = $clog2(POOL_PAGES + 1);

   // Field widths
   localparam int ENTRY_W  = 64;
   localparam int VIRT_W   = 48;
   localparam int PHYS_W   = 52;
   localparam int PPN_W    = 40;
   localparam int OFFSET_W = 12;
   localparam int CSR_IDX_W = 2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PRESENT_FLAG  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITABLE_FLAG = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE     = 2'd2;

   // Result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
   localparam logic [1:0] STATUS_OUTSIDE   = 2'd2;

   // Last table walk level; the level after it selects the leaf index
   localparam logic [1:0] LAST_TABLE_LEVEL = 2'd2;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_EVAL,
      S_CHECK,
      S_LEAF,
      S_DONE
   } ptmi_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic       clear_en;
      logic       load;
      logic       rd_en;
      logic       take_entry;
      logic       alloc;
      logic       check_adv;
      logic       leaf_wr;
      logic       set_status;
      logic [1:0] status_code;
      logic       finish;
   } ptmi_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic clear_last;
      logic present;
      logic pool_full;
      logic ptr_ok;
      logic last_level;
      logic rsp_free;
   } ptmi_sts_type;

endpackage

// ----- hw/rtl/page_table_map_insert.sv -----
// Top level of the page table map insert block.
// Joins ptmi_ctrl and ptmi_dp; depends on ptmi_pkg.
//
//   port group   direction  handshake          payload
//   req_*        in         req_valid/stall    virt_addr, phys_addr, map_flags
//   rsp_*        out        rsp_valid/stall    status, tables_added, leaf_entry
//   csr_*        in         csr_write          csr_index, csr_wdata
//
// A full walk runs three table levels of read, decide and pointer check
// on the single-port table store, then the leaf write and the result
// load. An error ends the walk early.
// After reset the store is swept to zero, one entry a cycle, over all
// POOL_PAGES*512 = 32768 entries; req_stall stays high meanwhile.
// The next item is taken while a result waits; a stalled result holds the
// walk in its final step.
module page_table_map_insert import ptmi_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [VIRT_W-1:0]    req_virt_addr,
   input  logic [PHYS_W-1:0]    req_phys_addr,
   input  logic [ENTRY_W-1:0]   req_map_flags,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [1:0]           rsp_tables_added,
   output logic [ENTRY_W-1:0]   rsp_leaf_entry,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ENTRY_W-1:0]   csr_wdata
);

   ptmi_cmd_type cmd;
   ptmi_sts_type sts;

   ptmi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ptmi_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_virt_addr    (req_virt_addr),
      .req_phys_addr    (req_phys_addr),
      .req_map_flags    (req_map_flags),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_tables_added (rsp_tables_added),
      .rsp_leaf_entry   (rsp_leaf_entry)
   );

endmodule

// ----- hw/rtl/ptmi_ctrl.sv -----
// Walk controller for the page table map insert block.
// Depends on ptmi_pkg for the state enum and the command/status structs.
module ptmi_ctrl import ptmi_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  ptmi_sts_type sts,
   output ptmi_cmd_type cmd
);

   ptmi_state_type state_ff;
   ptmi_state_type state_in;

   // State register; reset starts the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (sts.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_READ;
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (!sts.present && sts.pool_full) state_in = S_DONE;
            else state_in = S_CHECK;
         end
         S_CHECK: begin
            priority if (!sts.ptr_ok) state_in = S_DONE;
            else if (sts.last_level) state_in = S_LEAF;
            else state_in = S_READ;
         end
         S_LEAF: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (sts.rsp_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_en = 1'b1;
         end
         S_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
         end
         S_EVAL: begin
            priority if (sts.present) begin
               cmd.take_entry = 1'b1;
            end else if (sts.pool_full) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STATUS_EXHAUSTED;
            end else begin
               cmd.alloc = 1'b1;
            end
         end
         S_CHECK: begin
            if (!sts.ptr_ok) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STATUS_OUTSIDE;
            end else begin
               cmd.check_adv = 1'b1;
            end
         end
         S_LEAF: begin
            cmd.leaf_wr = 1'b1;
         end
         S_DONE: begin
            cmd.finish = sts.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ----- hw/rtl/ptmi_dp.sv -----
// Datapath for the page table map insert block: table store, walk registers,
// configuration registers and result register. Depends on ptmi_pkg.
module ptmi_dp import ptmi_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  ptmi_cmd_type         cmd,
   output ptmi_sts_type         sts,
   input  logic [VIRT_W-1:0]    req_virt_addr,
   input  logic [PHYS_W-1:0]    req_phys_addr,
   input  logic [ENTRY_W-1:0]   req_map_flags,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ENTRY_W-1:0]   csr_wdata,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [1:0]           rsp_tables_added,
   output logic [ENTRY_W-1:0]   rsp_leaf_entry
);

   // Configuration registers
   logic [ENTRY_W-1:0] present_ff;
   logic [ENTRY_W-1:0] writable_ff;
   logic [PHYS_W-1:0]  base_ff;

   // Walk registers
   logic [VIRT_W-1:0]       virt_ff;
   logic [PHYS_W-1:0]       phys_ff;
   logic [ENTRY_W-1:0]      flags_ff;
   logic [1:0]              level_ff;
   logic [PAGE_W-1:0]       page_ff;
   logic [1:0]              added_ff;
   logic [1:0]              status_ff;
   logic [ENTRY_W-1:0]      leaf_ff;
   logic [ENTRY_W-1:0]      entry_ff;
   logic [NFP_W-1:0]        nfp_ff;
   logic [STORE_ADDR_W-1:0] clear_cnt_ff;

   // Result register
   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic [1:0]         rsp_added_ff;
   logic [ENTRY_W-1:0] rsp_leaf_ff;

   // Table store
   logic [ENTRY_W-1:0]      mem [STORE_DEPTH];
   logic [ENTRY_W-1:0]      rd_data_ff;
   logic                    mem_we;
   logic [STORE_ADDR_W-1:0] mem_addr;
   logic [ENTRY_W-1:0]      mem_wdata;

   logic [IDX_W-1:0]   idx;
   logic [PPN_W-1:0]   new_ppn;
   logic [ENTRY_W-1:0] new_entry;
   logic [ENTRY_W-1:0] leaf_val;
   logic [PPN_W:0]     ptr_diff;
   logic               rsp_free;

   // Pick the index bits for the current level; the level after the last
   // table level selects the leaf entry
   always_comb begin
      unique case (level_ff)
         2'd0:    idx = virt_ff[47:39];
         2'd1:    idx = virt_ff[38:30];
         2'd2:    idx = virt_ff[29:21];
         default: idx = virt_ff[20:12];
      endcase
   end

   // New table pointer and leaf value
   assign new_ppn   = base_ff[PHYS_W-1:OFFSET_W] + PPN_W'(nfp_ff);
   assign new_entry = {12'b0, new_ppn, 12'b0} | present_ff | writable_ff;
   assign leaf_val  = {12'b0, phys_ff[PHYS_W-1:OFFSET_W], 12'b0} | flags_ff | present_ff;

   // Pointer range check against the pool base
   assign ptr_diff = {1'b0, entry_ff[PHYS_W-1:OFFSET_W]}
                   - {1'b0, base_ff[PHYS_W-1:OFFSET_W]};

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      sts.clear_last = (clear_cnt_ff == STORE_ADDR_W'(STORE_DEPTH - 1));
      sts.present    = rd_data_ff[0];
      sts.pool_full  = (nfp_ff == NFP_W'(POOL_PAGES));
      sts.ptr_ok     = !ptr_diff[PPN_W] && (ptr_diff < (PPN_W + 1)'(POOL_PAGES));
      sts.last_level = (level_ff == LAST_TABLE_LEVEL);
      sts.rsp_free   = rsp_free;
   end

   // Store address and write data
   always_comb begin
      mem_we    = cmd.clear_en || cmd.alloc || cmd.leaf_wr;
      mem_addr  = cmd.clear_en ? clear_cnt_ff : {page_ff, idx};
      priority if (cmd.clear_en) mem_wdata = '0;
      else if (cmd.alloc) mem_wdata = new_entry;
      else mem_wdata = leaf_val;
   end

   // Single-port table store with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   // Configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff  <= 64'd1;
         writable_ff <= 64'd2;
         base_ff     <= '0;
      end else if (csr_write) begin
         if (csr_index == CSR_PRESENT_FLAG)  present_ff  <= csr_wdata;
         if (csr_index == CSR_WRITABLE_FLAG) writable_ff <= csr_wdata;
         if (csr_index == CSR_POOL_BASE)     base_ff     <= csr_wdata[PHYS_W-1:0];
      end
   end

   // Clearing sweep counter and free page counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
         nfp_ff       <= NFP_W'(1);
      end else begin
         if (cmd.clear_en) clear_cnt_ff <= clear_cnt_ff + 1'b1;
         if (cmd.alloc) nfp_ff <= nfp_ff + 1'b1;
      end
   end

   // Walk registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         virt_ff   <= req_virt_addr;
         phys_ff   <= req_phys_addr;
         flags_ff  <= req_map_flags;
         level_ff  <= '0;
         page_ff   <= '0;
         added_ff  <= '0;
         status_ff <= STATUS_OK;
         leaf_ff   <= '0;
      end else begin
         if (cmd.take_entry) entry_ff <= rd_data_ff;
         if (cmd.alloc) begin
            entry_ff <= new_entry;
            added_ff <= added_ff + 1'b1;
         end
         if (cmd.check_adv) begin
            page_ff  <= ptr_diff[PAGE_W-1:0];
            level_ff <= level_ff + 1'b1;
         end
         if (cmd.leaf_wr) leaf_ff <= leaf_val;
         if (cmd.set_status) status_ff <= cmd.status_code;
      end
   end

   // Result register: load on finish, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff <= status_ff;
         rsp_added_ff  <= added_ff;
         rsp_leaf_ff   <= leaf_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_tables_added = rsp_added_ff;
   assign rsp_leaf_entry   = rsp_leaf_ff;

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for page_table_map_insert: four-level page table walks and inserts.
// Predicts each result with its own table pool copy; depends on ptmi_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb;
   import ptmi_pkg::*;

   localparam int                   WATCHDOG_LIMIT  = 150000;
   localparam int                   RSP_HOLD_CYCLES = 400;
   localparam int                   SETTLE_CYCLES   = 30;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX  = 2'd3;
   localparam logic [63:0]          PTR_MASK        = 64'h000F_FFFF_FFFF_F000;
   localparam logic [63:0]          MASK52          = 64'h000F_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [1:0]         status;
      logic [1:0]         added;
      logic [ENTRY_W-1:0] leaf;
   } map_result_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [VIRT_W-1:0]    req_virt_addr;
   logic [PHYS_W-1:0]    req_phys_addr;
   logic [ENTRY_W-1:0]   req_map_flags;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [1:0]           rsp_status;
   logic [1:0]           rsp_tables_added;
   logic [ENTRY_W-1:0]   rsp_leaf_entry;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ENTRY_W-1:0]   csr_wdata;

   // Predicted block state
   logic [ENTRY_W-1:0] table_mem [STORE_DEPTH];
   int unsigned        free_page;
   logic [ENTRY_W-1:0] present_q;
   logic [ENTRY_W-1:0] writable_q;
   logic [PHYS_W-1:0]  pool_base_q;

   map_result_type pending_maps [$];
   logic [VIRT_W-1:0] path_va [6];

   int error_count   = 0;
   int rsp_count     = 0;
   int quiet_cycles  = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left     = 0;
   bit hold_request  = 1'b0;

   page_table_map_insert uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_error(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Walk the predicted tables, allocate missing levels and write the leaf
   function automatic map_result_type walk_and_map(input logic [VIRT_W-1:0] va,
                                                   input logic [PHYS_W-1:0] pa,
                                                   input logic [ENTRY_W-1:0] fl);
      map_result_type r;
      int unsigned    page;
      int unsigned    slot;
      int             shift;
      logic [63:0]    entry;
      logic [63:0]    ptr;
      logic [63:0]    base;
      logic [63:0]    new_addr;
      r     = '0;
      page  = 0;
      base  = {12'b0, pool_base_q} & PTR_MASK;
      shift = 39;
      while (shift >= 21 && r.status == STATUS_OK) begin
         slot  = page * ENTRIES_PER_PAGE + int'(va[shift +: IDX_W]);
         entry = table_mem[slot];
         if (!entry[0] && free_page >= POOL_PAGES) begin
            r.status = STATUS_EXHAUSTED;
         end else begin
            if (!entry[0]) begin
               new_addr = (base + (64'(free_page) << OFFSET_W)) & MASK52;
               free_page++;
               r.added = r.added + 2'd1;
               entry = new_addr | present_q | writable_q;
               table_mem[slot] = entry;
            end
            ptr = entry & PTR_MASK;
            if (ptr < base || ((ptr - base) >> OFFSET_W) >= POOL_PAGES) begin
               r.status = STATUS_OUTSIDE;
            end else begin
               page = int'((ptr - base) >> OFFSET_W);
            end
         end
         shift -= 9;
      end
      if (r.status == STATUS_OK) begin
         r.leaf = ({12'b0, pa} & PTR_MASK) | fl | present_q;
         table_mem[page * ENTRIES_PER_PAGE + int'(va[OFFSET_W +: IDX_W])] = r.leaf;
      end
      return r;
   endfunction

   // Offer one map request, with random idle gaps before it
   task automatic send_map(input logic [VIRT_W-1:0] va, input logic [PHYS_W-1:0] pa,
                           input logic [ENTRY_W-1:0] fl);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_virt_addr <= va;
      req_phys_addr <= pa;
      req_map_flags <= fl;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_maps.push_back(walk_and_map(va, pa, fl));
      @(negedge clock);
   endtask

   // Drop valid and wait until every predicted result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_maps.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_reg(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] data);
      drain_results();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_PRESENT_FLAG:  present_q  = data;
         CSR_WRITABLE_FLAG: writable_q = data;
         CSR_POOL_BASE:     pool_base_q = data[PHYS_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // Offer one map request with random addresses and flags
   task automatic send_random_full();
      send_map(VIRT_W'(rand64()), PHYS_W'(rand64()), rand64());
   endtask

   // Mostly reuse a few known paths with random leaf slots; sometimes a fresh path
   task automatic send_random_maps(input int count);
      logic [VIRT_W-1:0] va;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 3) begin
            va = VIRT_W'(rand64());
         end else begin
            va = {path_va[$urandom_range(5)][47:21], 9'($urandom), 12'($urandom)};
         end
         send_map(va, PHYS_W'(rand64()), rand64());
      end
   endtask

   // Receiver: random stalls, or a long hold-off on request
   always @(negedge clock) begin
      if (hold_left == 0 && hold_request) begin
         hold_left    = RSP_HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Compare each accepted result with the oldest prediction
   always @(posedge clock) begin : check_results
      map_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (pending_maps.size() == 0) begin
            report_error($sformatf("result %0d arrived with no request pending", rsp_count));
         end else begin
            want = pending_maps.pop_front();
            if (rsp_status !== want.status)
               report_error($sformatf("result %0d status got %0d want %0d",
                                      rsp_count, rsp_status, want.status));
            if (rsp_tables_added !== want.added)
               report_error($sformatf("result %0d tables_added got %0d want %0d",
                                      rsp_count, rsp_tables_added, want.added));
            if (rsp_leaf_entry !== want.leaf)
               report_error($sformatf("result %0d leaf_entry got %h want %h",
                                      rsp_count, rsp_leaf_entry, want.leaf));
         end
      end
   end

   // Watchdog: end the run after too many cycles without a handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Fresh walks, repeat walks, address and flag extremes
   task automatic test_basic_maps();
      send_map(48'h0, 52'h0, 64'h0);
      send_map(48'h0, '1, '1);
      send_map('1, 52'h8_0000_0000_0000, 64'h0);
      send_map(48'h007F_FFFF_F000, 52'h0_0000_0000_1FFF, 64'h8000_0000_0000_0000);
   endtask

   // New pointers lack bit 0, so the same walk allocates again
   task automatic test_present_without_bit0();
      set_reg(CSR_PRESENT_FLAG, 64'h4);
      send_map(48'h0080_4020_1000, 52'h1_2345_6789_A000, 64'h10);
      send_map(48'h0080_4020_1000, 52'h1_2345_6789_B000, 64'h20);
      set_reg(CSR_PRESENT_FLAG, 64'h1);
   endtask

   // Moved pool: old pointers fall outside; new page addresses wrap at 2^52
   task automatic test_pool_relocation();
      set_reg(CSR_POOL_BASE, 64'h4_0ABC);
      send_map(48'h0, 52'h5000, 64'h0);
      send_map(48'h0100_0000_0000, 52'h6000, 64'h2);
      set_reg(CSR_POOL_BASE, '1);
      send_map(48'h0180_0000_0000, 52'h7000, 64'h4);
      set_reg(CSR_POOL_BASE, 64'h0);
   endtask

   // All-ones and all-zero flag registers, plus a write to an unused index
   task automatic test_flag_extremes();
      set_reg(CSR_PRESENT_FLAG, '1);
      send_map(48'h0200_0000_0000, PHYS_W'(rand64()), rand64());
      set_reg(CSR_PRESENT_FLAG, 64'h0);
      set_reg(CSR_WRITABLE_FLAG, '1);
      send_map(48'h0280_0000_0000, PHYS_W'(rand64()), rand64());
      set_reg(CSR_WRITABLE_FLAG, 64'h0);
      send_map(48'h0300_0000_0000, PHYS_W'(rand64()), 64'h0);
      set_reg(CSR_UNUSED_IDX, '1);
      set_reg(CSR_PRESENT_FLAG, 64'h1);
      set_reg(CSR_WRITABLE_FLAG, 64'h2);
      send_map(48'h0300_0000_0000, PHYS_W'(rand64()), 64'h0);
   endtask

   // Random maps with extra attribute bits in the flag registers
   task automatic test_random_attr_flags();
      path_va[0] = 48'h0;
      path_va[1] = '1;
      path_va[2] = 48'h007F_FFFF_F000;
      path_va[3] = 48'h0300_0000_0000;
      path_va[4] = VIRT_W'(rand64());
      path_va[5] = VIRT_W'(rand64());
      set_reg(CSR_PRESENT_FLAG, (rand64() & ~PTR_MASK) | 64'h1);
      set_reg(CSR_WRITABLE_FLAG, rand64() & ~PTR_MASK);
      send_random_maps(370);
   endtask

   // Random maps with the pool shifted so that old pointers alias other pages
   task automatic test_random_aliased_pool();
      set_reg(CSR_POOL_BASE, 64'h8000 | 64'($urandom_range(12'hFFF)));
      set_reg(CSR_PRESENT_FLAG, rand64() & ~PTR_MASK);
      send_random_maps(185);
      set_reg(CSR_POOL_BASE, 64'($urandom_range(12'hFFF)));
      set_reg(CSR_PRESENT_FLAG, (rand64() & ~PTR_MASK) | 64'h1);
      send_random_maps(185);
   endtask

   // Hold the receiver off while requests keep coming, so the input stalls
   task automatic test_backpressure();
      set_reg(CSR_PRESENT_FLAG, 64'h1);
      set_reg(CSR_WRITABLE_FLAG, 64'h2);
      set_reg(CSR_POOL_BASE, 64'h0);
      hold_request = 1'b1;
      send_random_maps(380);
   endtask

   // Take fresh paths until the pool runs dry, then ask for more
   task automatic test_pool_exhaustion();
      int n;
      n = 0;
      while (free_page < POOL_PAGES && n < 20) begin
         send_random_full();
         n++;
      end
      send_random_full();
      send_random_full();
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_virt_addr = '0;
      req_phys_addr = '0;
      req_map_flags = '0;
      rsp_stall     = 1'b0;
      csr_write     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      foreach (table_mem[i]) table_mem[i] = '0;
      free_page   = 1;
      present_q   = 64'h1;
      writable_q  = 64'h2;
      pool_base_q = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 18;
      recv_idle_pct = 64;
      test_basic_maps();
      test_present_without_bit0();
      test_pool_relocation();
      test_flag_extremes();
      test_random_attr_flags();

      send_idle_pct = 64;
      recv_idle_pct = 18;
      test_random_aliased_pool();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      test_pool_exhaustion();

      drain_results();
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
